// ----- sv/stack_machine_executor_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stack machine executor
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_ASSERT_SVH
`ifndef ASSERT_OFF
// property holds at every edge
`define SME_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition implies expression at the next edge
`define SME_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define SME_ASSERT(label, prop, msg)
`define SME_ASSERT_NEXT(label, cond, expr, msg)
`endif
`endif

// ----- sv/sme_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sme_pkg
// Sizes, stream packing and instruction/error codes of the stack machine.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int STACK_DEPTH  = 64;
    localparam int RETURN_DEPTH = 16;
    localparam int PC_BITS      = 12;
    localparam int NUM_VREGS    = 5;

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int RP_W = $clog2(RETURN_DEPTH + 1);
    localparam int RA_W = $clog2(RETURN_DEPTH);

    // field widths of the stream items
    localparam int OP_W   = 4;
    localparam int VAL_W  = 32;
    localparam int RI_W   = 3;
    localparam int ADDR_W = 12;
    localparam int ERR_W  = 3;

    localparam int IN_BITS     = OP_W + VAL_W + RI_W + ADDR_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = ADDR_W + VAL_W + 1 + ERR_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_IMM = 4'd0,
        OP_PUSH_REG = 4'd1,
        OP_ADD      = 4'd2,
        OP_SUB      = 4'd3,
        OP_MUL      = 4'd4,
        OP_POP_REG  = 4'd5,
        OP_JUMP     = 4'd6,
        OP_CALL     = 4'd7,
        OP_RET      = 4'd8,
        OP_JNZ      = 4'd9,
        OP_OUT      = 4'd10,
        OP_HALT     = 4'd11
    } opcode_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_ILLEGAL   = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_OVERFLOW  = 3'd3,
        ERR_RET_EMPTY = 3'd4,
        ERR_RET_FULL  = 3'd5
    } error_t;

endpackage
`default_nettype wire

// ----- sv/sme_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sme_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- sv/stack_machine_executor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_executor
// Executes one decoded stack machine instruction per input item.
//
// Input channel s_*: one decoded instruction per item (opcode, immediate,
// register index, resolved target). Output channel m_*: one result item per
// instruction (next pc, halted flag, error code, output value; out_valid in
// m_tuser). No configuration port.
// Pipeline: an accepted item waits in the input register and is executed
// from it once the output can advance; the result register offers it on m_*.
// Throughput: one instruction per cycle unless m_tready stalls. Top two stack
// entries live in registers; deeper ones sit in a RAM whose registered read is
// launched one instruction early, so every instruction finishes in one pass.
// Reset: stack and return pointers, pc, value registers and halt flag clear;
// both channels go empty. Stack RAM contents are don't-care until pushed.
// Stall: while m_tready is low the result holds and one more instruction can
// wait in the input register; s_tready then drops.
// ----------------------------------------------------------------------------
`include "stack_machine_executor_assert.svh"
module stack_machine_executor
    import sme_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // opcode[3:0], immediate[35:4], reg_index[38:36], target[50:39], zero pad
    input  wire [IN_TDATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    // next_pc[11:0], out_value[43:12], halted[44], error[47:45]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // out_valid[0]
    output logic [0:0]             m_tuser
);

    // ---------------- input register ----------------
    logic              in_vld_reg;
    logic [OP_W-1:0]   op_reg;
    logic [VAL_W-1:0]  imm_reg;
    logic [RI_W-1:0]   ri_reg;
    logic [ADDR_W-1:0] tgt_reg;

    logic advance;
    logic exec;
    logic s_acc;

    assign advance  = !m_tvalid || m_tready;
    assign exec     = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_acc)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (exec)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            op_reg  <= s_tdata[OP_W-1:0];
            imm_reg <= s_tdata[OP_W +: VAL_W];
            ri_reg  <= s_tdata[OP_W+VAL_W +: RI_W];
            tgt_reg <= s_tdata[OP_W+VAL_W+RI_W +: ADDR_W];
        end
    end

    // ---------------- machine state ----------------
    logic [SP_W-1:0]    sp_reg, sp_next;
    logic [RP_W-1:0]    rp_reg, rp_next;
    logic [PC_BITS-1:0] pc_reg, pc_next;
    logic               halt_reg, halt_next;
    logic [VAL_W-1:0]   tos_reg, tos_next;    // top of stack
    logic [VAL_W-1:0]   nos_reg, nos_next;    // next of stack
    logic [VAL_W-1:0]   vreg_reg [NUM_VREGS];
    logic [PC_BITS-1:0] rs_mem [RETURN_DEPTH];

    // third entry: RAM read launched last cycle, bypassed after a spill
    logic               byp_reg;
    logic [VAL_W-1:0]   byp_data_reg;
    logic [VAL_W-1:0]   ram_rdata;
    logic [VAL_W-1:0]   third;
    logic               ram_we;
    logic [SP_W-1:0]    ram_wsp;
    logic [SP_W-1:0]    ram_rsp;

    assign third   = byp_reg ? byp_data_reg : ram_rdata;
    assign ram_wsp = sp_reg - SP_W'(2);
    assign ram_rsp = sp_next - SP_W'(3);

    sme_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_wsp[SA_W-1:0]),
        .wdata (nos_reg),
        .raddr (ram_rsp[SA_W-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------- execute ----------------
    function automatic logic [VAL_W-1:0] sat48(input logic signed [47:0] v);
        if (v > 48'sd2147483647)
        begin
            return 32'h7FFF_FFFF;
        end
        else if (v < -48'sd2147483648)
        begin
            return 32'h8000_0000;
        end
        return v[VAL_W-1:0];
    endfunction

    logic signed [VAL_W:0]     sum;
    logic signed [VAL_W:0]     diff;
    logic signed [2*VAL_W-1:0] prod;
    logic [VAL_W-1:0]          arith;
    logic                      ri_bad;
    logic [VAL_W-1:0]          push_val;
    logic [PC_BITS-1:0]        pc_inc;
    logic [RP_W-1:0]           rp_dec;
    logic                      vreg_we;
    logic                      rs_we;
    logic                      res_ov;
    logic [VAL_W-1:0]          res_oval;
    error_t                    res_err;

    assign sum    = $signed({tos_reg[VAL_W-1], tos_reg}) + $signed({nos_reg[VAL_W-1], nos_reg});
    assign diff   = $signed({tos_reg[VAL_W-1], tos_reg}) - $signed({nos_reg[VAL_W-1], nos_reg});
    assign prod   = $signed(tos_reg) * $signed(nos_reg);
    assign ri_bad = ri_reg >= RI_W'(NUM_VREGS);
    assign pc_inc = pc_reg + PC_BITS'(1);
    assign rp_dec = rp_reg - RP_W'(1);

    always_comb
    begin
        case (op_reg)
            OP_ADD:  arith = sat48({{(47-VAL_W){sum[VAL_W]}}, sum});
            OP_SUB:  arith = sat48({{(47-VAL_W){diff[VAL_W]}}, diff});
            default: arith = sat48(prod[2*VAL_W-1:16]);   // floor shift of Q16.16 product
        endcase
    end

    always_comb
    begin
        push_val = (op_reg == OP_PUSH_REG && !ri_bad) ? vreg_reg[ri_reg] : imm_reg;
    end

    always_comb
    begin
        sp_next   = sp_reg;
        rp_next   = rp_reg;
        pc_next   = pc_reg;
        halt_next = halt_reg;
        tos_next  = tos_reg;
        nos_next  = nos_reg;
        ram_we    = 1'b0;
        vreg_we   = 1'b0;
        rs_we     = 1'b0;
        res_ov    = 1'b0;
        res_oval  = '0;
        res_err   = ERR_NONE;
        if (exec && !halt_reg)
        begin
            pc_next = pc_inc;
            case (op_reg)
                OP_PUSH_IMM, OP_PUSH_REG:
                begin
                    if (op_reg == OP_PUSH_REG && ri_bad)
                    begin
                        res_err = ERR_ILLEGAL;
                    end
                    else if (sp_reg >= SP_W'(STACK_DEPTH))
                    begin
                        res_err = ERR_OVERFLOW;
                    end
                    else
                    begin
                        tos_next = push_val;
                        nos_next = tos_reg;
                        sp_next  = sp_reg + SP_W'(1);
                        ram_we   = sp_reg >= SP_W'(2);   // spill old next-of-stack
                    end
                end
                OP_ADD, OP_SUB, OP_MUL:
                begin
                    if (sp_reg < SP_W'(2))
                    begin
                        res_err = ERR_UNDERFLOW;
                    end
                    else
                    begin
                        tos_next = arith;
                        nos_next = third;
                        sp_next  = sp_reg - SP_W'(1);
                    end
                end
                OP_POP_REG:
                begin
                    if (ri_bad)
                    begin
                        res_err = ERR_ILLEGAL;
                    end
                    else if (sp_reg == '0)
                    begin
                        res_err = ERR_UNDERFLOW;
                    end
                    else
                    begin
                        vreg_we  = 1'b1;
                        tos_next = nos_reg;
                        nos_next = third;
                        sp_next  = sp_reg - SP_W'(1);
                    end
                end
                OP_JUMP:
                begin
                    pc_next = PC_BITS'(tgt_reg);
                end
                OP_CALL:
                begin
                    if (rp_reg >= RP_W'(RETURN_DEPTH))
                    begin
                        res_err = ERR_RET_FULL;
                    end
                    else
                    begin
                        rs_we   = 1'b1;
                        rp_next = rp_reg + RP_W'(1);
                        pc_next = PC_BITS'(tgt_reg);
                    end
                end
                OP_RET:
                begin
                    if (rp_reg == '0)
                    begin
                        res_err = ERR_RET_EMPTY;
                    end
                    else
                    begin
                        rp_next = rp_dec;
                        pc_next = rs_mem[rp_dec[RA_W-1:0]];
                    end
                end
                OP_JNZ:
                begin
                    if (sp_reg == '0)
                    begin
                        res_err = ERR_UNDERFLOW;
                    end
                    else
                    begin
                        tos_next = nos_reg;
                        nos_next = third;
                        sp_next  = sp_reg - SP_W'(1);
                        if (tos_reg != '0)
                        begin
                            pc_next = PC_BITS'(tgt_reg);
                        end
                    end
                end
                OP_OUT:
                begin
                    if (sp_reg == '0)
                    begin
                        res_err = ERR_UNDERFLOW;
                    end
                    else
                    begin
                        res_ov   = 1'b1;
                        res_oval = tos_reg;
                    end
                end
                OP_HALT:
                begin
                    halt_next = 1'b1;
                    pc_next   = pc_reg;
                end
                default:
                begin
                    res_err = ERR_ILLEGAL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg   <= '0;
            rp_reg   <= '0;
            pc_reg   <= '0;
            halt_reg <= 1'b0;
            byp_reg  <= 1'b0;
            for (int i = 0; i < NUM_VREGS; i++)
            begin
                vreg_reg[i] <= '0;
            end
        end
        else
        begin
            sp_reg   <= sp_next;
            rp_reg   <= rp_next;
            pc_reg   <= pc_next;
            halt_reg <= halt_next;
            byp_reg  <= ram_we;
            if (vreg_we)
            begin
                vreg_reg[ri_reg] <= tos_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg      <= tos_next;
        nos_reg      <= nos_next;
        byp_data_reg <= nos_reg;
        if (rs_we)
        begin
            rs_mem[rp_reg[RA_W-1:0]] <= pc_inc;
        end
    end

    // ---------------- result register ----------------
    logic               m_vld_reg;
    logic [PC_BITS-1:0] res_pc_reg;
    logic               res_ov_reg;
    logic [VAL_W-1:0]   res_oval_reg;
    logic               res_halt_reg;
    error_t             res_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else if (exec)
        begin
            m_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            res_pc_reg   <= pc_next;
            res_ov_reg   <= res_ov;
            res_oval_reg <= res_oval;
            res_halt_reg <= halt_next;
            res_err_reg  <= res_err;
        end
    end

    assign m_tvalid   = m_vld_reg;
    assign m_tuser[0] = res_ov_reg;
    assign m_tdata    = OUT_TDATA_W'({res_err_reg, res_halt_reg, res_oval_reg,
                                      ADDR_W'(res_pc_reg)});

    // ---------------- checks ----------------
    `SME_ASSERT(a_sp_range, sp_reg <= SP_W'(STACK_DEPTH), "operand stack pointer out of range")
    `SME_ASSERT(a_rp_range, rp_reg <= RP_W'(RETURN_DEPTH), "return stack pointer out of range")
    `SME_ASSERT_NEXT(a_halt_sticky, halt_reg, halt_reg, "halt flag cleared without reset")
    `SME_ASSERT_NEXT(a_halt_frozen, halt_reg, $stable(pc_reg) && $stable(sp_reg) && $stable(rp_reg), "state moved while halted")
    `SME_ASSERT(a_err_no_out, !(m_vld_reg && res_err_reg != ERR_NONE && res_ov_reg), "output value flagged on an error result")

endmodule
`default_nettype wire
